// ----- rtl/htd_pkg.sv -----
// shared types and constants of the huffman table decoder
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;

  // request kinds on the input channel
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_BIT  = 1'b1;

  // table write from the sequencer
  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_wr_t;

  // registered table read data, length forced to zero for unused entries
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_rd_t;

  // finished decode result towards the output register
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             error;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/htd_if.sv -----
// channel interfaces of the huffman table decoder
`timescale 1ns / 1ps
`default_nettype none

interface htd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [htd_pkg::SYM_W-1:0]  entry_symbol;
  logic [htd_pkg::CODE_W-1:0] entry_code;
  logic [htd_pkg::LEN_W-1:0]  entry_length;
  logic                      code_bit;
  logic                      last_bit;

  modport source (output valid, action, entry_symbol, entry_code, entry_length,
                  code_bit, last_bit, input ready);
  modport sink (input valid, action, entry_symbol, entry_code, entry_length,
                code_bit, last_bit, output ready);
endinterface

interface htd_out_if;
  logic                     valid;
  logic                     ready;
  logic [htd_pkg::SYM_W-1:0] symbol;
  logic                     error;

  modport source (output valid, symbol, error, input ready);
  modport sink (input valid, symbol, error, output ready);
endinterface

`default_nettype wire

// ----- rtl/htd_table.sv -----
// code table memory with per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none

module htd_table #(
  parameter int TABLE_SIZE = 256
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  htd_pkg::tbl_wr_t             wr,
  input  wire [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output htd_pkg::tbl_rd_t             rd
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int DW = htd_pkg::CODE_W + htd_pkg::LEN_W;

  logic [DW-1:0]         mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] used_r;
  logic [DW-1:0]         rd_data_r;
  logic                  rd_used_r;
  logic                  wr_hit;

  // symbols beyond the table are dropped
  assign wr_hit = wr.en && ((htd_pkg::SYM_W + 1)'(wr.sym) < (htd_pkg::SYM_W + 1)'(TABLE_SIZE));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr.sym[AW-1:0]] <= {wr.code, wr.len};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (wr_hit) begin
        used_r[wr.sym[AW-1:0]] <= 1'b1;
      end
      rd_used_r <= used_r[rd_addr];
    end
  end

  assign rd.code = rd_data_r[DW-1:htd_pkg::LEN_W];
  assign rd.len  = rd_used_r ? rd_data_r[htd_pkg::LEN_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- rtl/htd_scan.sv -----
// request sequencer: table writes for loads, prefix update and table sweep for each code bit
`timescale 1ns / 1ps
`default_nettype none

module htd_scan #(
  parameter int TABLE_SIZE   = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  htd_in_if.sink                       in_req,
  output htd_pkg::tbl_wr_t             wr,
  output logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  input  htd_pkg::tbl_rd_t             rd,
  output htd_pkg::res_t                res,
  input  wire                          res_ready
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int PLW = $clog2(MAX_CODE_LEN + 1);
  localparam int CW  = (MAX_CODE_LEN > htd_pkg::CODE_W) ? MAX_CODE_LEN : htd_pkg::CODE_W;
  localparam int LCW = 7;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_TAIL, ST_DONE} state_t;

  state_t                  state_r;
  logic [MAX_CODE_LEN-1:0] prefix_r;
  logic [PLW-1:0]          plen_r;
  logic                    last_r;
  logic [AW-1:0]           addr_r;
  logic [AW-1:0]           idx_d_r;
  logic                    cmp_v_r;
  logic                    found_r;
  logic [AW-1:0]           hit_r;
  logic                    accept;
  logic                    match;
  logic [CW-1:0]           len_mask;
  logic                    res_due;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  assign wr.en   = accept && (in_req.action == htd_pkg::ACT_LOAD);
  assign wr.sym  = in_req.entry_symbol;
  assign wr.code = in_req.entry_code;
  assign wr.len  = in_req.entry_length;

  assign rd_addr = addr_r;

  // entry compare on the registered read data
  assign len_mask = ~({CW{1'b1}} << rd.len);
  assign match = (rd.len != '0) &&
                 (LCW'(rd.len) <= LCW'(MAX_CODE_LEN)) &&
                 (LCW'(rd.len) == LCW'(plen_r)) &&
                 ((CW'(rd.code) & len_mask) == CW'(prefix_r));

  assign res_due    = found_r || (plen_r >= PLW'(MAX_CODE_LEN)) || last_r;
  assign res.valid  = (state_r == ST_DONE) && res_due;
  assign res.symbol = found_r ? htd_pkg::SYM_W'(hit_r) : '0;
  assign res.error  = !found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      prefix_r <= '0;
      plen_r   <= '0;
      last_r   <= 1'b0;
      addr_r   <= '0;
      idx_d_r  <= '0;
      cmp_v_r  <= 1'b0;
      found_r  <= 1'b0;
      hit_r    <= '0;
    end else begin
      cmp_v_r <= (state_r == ST_SCAN);
      idx_d_r <= addr_r;
      if (cmp_v_r && match) begin
        found_r <= 1'b1;
        hit_r   <= idx_d_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_req.action == htd_pkg::ACT_BIT)) begin
            prefix_r <= (prefix_r << 1) | MAX_CODE_LEN'(in_req.code_bit);
            plen_r   <= plen_r + 1'b1;
            last_r   <= in_req.last_bit;
            addr_r   <= '0;
            found_r  <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_r == LAST_ADDR) begin
            state_r <= ST_TAIL;
          end else begin
            addr_r <= addr_r + 1'b1;
          end
        end
        ST_TAIL: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_due) begin
            state_r <= ST_IDLE;
          end else if (res_ready) begin
            prefix_r <= '0;
            plen_r   <= '0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/huffman_table_decoder_core.sv -----
// top level of the huffman table decoder for byte symbols
//
// usage
//  - in_req carries two kinds of request: a load writes one code table entry
//    (symbol, code bits right aligned, length; length 0 leaves the entry unused),
//    a bit request shifts one stream bit into the running prefix
//  - out_res gives one result per decoded symbol, or an error result when the
//    prefix reaches MAX_CODE_LEN bits or the last stream bit leaves a partial code
// request handling
//  - a load writes its table entry as it is taken and gives no result
//  - a bit request sweeps the table memory one entry per cycle through its
//    single read port, compares each entry on the registered read data and
//    then puts any result into the output register; no new request is taken
//    until the sweep is over and any result is in the output register
// reset
//  - all table entries read as unused and the prefix is empty; no clearing pass
// stalls
//  - a result waits in the output register; the next request is still taken,
//    and only a further result waits until out_res.ready frees the register
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_decoder_core #(
  parameter int TABLE_SIZE   = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  htd_in_if.sink     in_req,
  htd_out_if.source  out_res
);

  localparam int AW = $clog2(TABLE_SIZE);

  htd_pkg::tbl_wr_t          wr;
  htd_pkg::tbl_rd_t          rd;
  htd_pkg::res_t             res;
  logic [AW-1:0]             rd_addr;
  logic                      res_ready;
  logic                      out_valid_r;
  logic [htd_pkg::SYM_W-1:0] symbol_r;
  logic                      error_r;

  // code table: one memory, registered read
  htd_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  // request handling and table sweep
  htd_scan #(
    .TABLE_SIZE   (TABLE_SIZE),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .wr        (wr),
    .rd_addr   (rd_addr),
    .rd        (rd),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register frees when empty or when the receiver takes its contents
  assign res_ready = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      symbol_r <= res.symbol;
      error_r  <= res.error;
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.symbol = symbol_r;
  assign out_res.error  = error_r;

endmodule

`default_nettype wire
